[src/tnob_pkg.sv]
// Shared types and constants for the top-N order book levels block.
`timescale 1ns / 1ps
package tnob_pkg;

  localparam int PRICE_BITS = 32;
  localparam int QTY_BITS   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMPTY_BID = 2'd0,
    CFG_EMPTY_ASK = 2'd1,
    CFG_MAX_QTY   = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    req_type_t             req_type;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
  } req_t;

  typedef struct packed {
    logic                  error;
    logic                  dropped;
    logic [PRICE_BITS-1:0] best_bid_price;
    logic [QTY_BITS-1:0]   best_bid_qty;
    logic [PRICE_BITS-1:0] best_ask_price;
    logic [QTY_BITS-1:0]   best_ask_qty;
  } res_t;

  // Classified request handed from front to back.
  typedef struct packed {
    req_type_t             req_type;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
    logic                  any_match;
    logic                  multi_match;
    logic                  worse_found;
  } cls_t;

endpackage

[src/tnob_fifo.sv]
// Small FIFO that decouples request classification from book update.
`timescale 1ns / 1ps
module tnob_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/tnob_front.sv]
// Front end: holds an accepted request and classifies it against the book.
`timescale 1ns / 1ps
module tnob_front #(
  parameter  int LEVELS = 8,
  localparam int IDX_W  = $clog2(LEVELS),
  localparam int ENT_W  = $bits(tnob_pkg::cls_t) + 2 * IDX_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  tnob_pkg::req_t                  item,
  input  logic [tnob_pkg::PRICE_BITS-1:0] bid_price [LEVELS],
  input  logic [tnob_pkg::PRICE_BITS-1:0] ask_price [LEVELS],
  input  logic                            q_full,
  output logic                            push,
  output logic [ENT_W-1:0]                push_data,
  output logic                            valid
);
  import tnob_pkg::*;

  logic                  valid_r;
  req_t                  item_r;
  logic [LEVELS-1:0]     match, better, first_better;
  logic [IDX_W-1:0]      hit_idx, worse_idx;
  logic [PRICE_BITS-1:0] sel_price [LEVELS];
  cls_t                  cls;

  assign valid = valid_r;
  assign push  = valid_r && !q_full;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      sel_price[i] = item_r.side ? ask_price[i] : bid_price[i];
      match[i]     = (sel_price[i] == item_r.price);
      better[i]    = item_r.side ? (item_r.price < sel_price[i])
                                 : (item_r.price > sel_price[i]);
    end
  end

  // Isolate the first level the new price beats.
  assign first_better = better & (~better + 1'b1);

  always_comb begin
    hit_idx   = '0;
    worse_idx = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (first_better[i]) begin
        worse_idx = worse_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    cls.req_type    = item_r.req_type;
    cls.side        = item_r.side;
    cls.price       = item_r.price;
    cls.qty         = item_r.qty;
    cls.any_match   = |match;
    cls.multi_match = |(match & (match - 1'b1));
    cls.worse_found = |better;
  end

  assign push_data = {cls, hit_idx, worse_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
  end

endmodule

[src/tnob_back.sv]
// Back end: applies classified requests to the bid and ask level tables.
`timescale 1ns / 1ps
module tnob_back #(
  parameter  int LEVELS = 8,
  localparam int IDX_W  = $clog2(LEVELS),
  localparam int ENT_W  = $bits(tnob_pkg::cls_t) + 2 * IDX_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  logic [ENT_W-1:0]                pop_data,
  input  logic [tnob_pkg::PRICE_BITS-1:0] empty_bid_price,
  input  logic [tnob_pkg::PRICE_BITS-1:0] empty_ask_price,
  input  logic [tnob_pkg::QTY_BITS-1:0]   max_level_qty,
  output logic                            pop,
  output logic [tnob_pkg::PRICE_BITS-1:0] bid_price [LEVELS],
  output logic [tnob_pkg::PRICE_BITS-1:0] ask_price [LEVELS],
  output logic                            out_valid,
  output tnob_pkg::res_t                  out_res
);
  import tnob_pkg::*;

  logic [PRICE_BITS-1:0] bid_p_r [LEVELS];
  logic [QTY_BITS-1:0]   bid_q_r [LEVELS];
  logic [PRICE_BITS-1:0] ask_p_r [LEVELS];
  logic [QTY_BITS-1:0]   ask_q_r [LEVELS];
  logic                  err_r, err_nxt;
  logic                  out_valid_r;
  res_t                  out_res_r;

  cls_t                  cls;
  logic [IDX_W-1:0]      hit_idx, worse_idx;
  logic [PRICE_BITS-1:0] sel_p [LEVELS];
  logic [QTY_BITS-1:0]   sel_q [LEVELS];
  logic [PRICE_BITS-1:0] new_p [LEVELS];
  logic [QTY_BITS-1:0]   new_q [LEVELS];
  logic [PRICE_BITS-1:0] side_empty;
  logic [QTY_BITS-1:0]   cur_q;
  logic [QTY_BITS:0]     sum;
  logic                  clear, wr, drop;
  res_t                  res_nxt;

  assign pop = !q_empty;
  assign {cls, hit_idx, worse_idx} = pop_data;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign bid_price = bid_p_r;
  assign ask_price = ask_p_r;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      sel_p[i] = cls.side ? ask_p_r[i] : bid_p_r[i];
      sel_q[i] = cls.side ? ask_q_r[i] : bid_q_r[i];
    end
  end

  assign side_empty = cls.side ? empty_ask_price : empty_bid_price;
  assign cur_q      = sel_q[hit_idx];
  assign sum        = {1'b0, cur_q} + {1'b0, cls.qty};

  always_comb begin
    new_p   = sel_p;
    new_q   = sel_q;
    err_nxt = err_r;
    clear   = 1'b0;
    wr      = 1'b0;
    drop    = 1'b0;
    unique case (cls.req_type)
      REQ_CLEAR: begin
        clear   = 1'b1;
        err_nxt = 1'b0;
      end
      REQ_INSERT, REQ_REMOVE: begin
        if (!err_r) begin
          if (cls.qty == '0 || cls.multi_match) begin
            err_nxt = 1'b1;
          end else if (cls.req_type == REQ_INSERT) begin
            if (cls.any_match) begin
              if (sum > {1'b0, max_level_qty}) begin
                err_nxt = 1'b1;
              end else begin
                wr = 1'b1;
                new_q[hit_idx] = sum[QTY_BITS-1:0];
              end
            end else if (!cls.worse_found) begin
              drop = 1'b1;
            end else begin
              // shift worse levels down one slot, new level goes in
              wr = 1'b1;
              for (int i = 1; i < LEVELS; i++) begin
                if (IDX_W'(i) > worse_idx) begin
                  new_p[i] = sel_p[i-1];
                  new_q[i] = sel_q[i-1];
                end
              end
              new_p[worse_idx] = cls.price;
              new_q[worse_idx] = cls.qty;
            end
          end else begin
            if (!cls.any_match || cur_q < cls.qty) begin
              err_nxt = 1'b1;
            end else if (cur_q == cls.qty) begin
              // delete level, pull the rest up, refill last slot empty
              wr = 1'b1;
              for (int i = 0; i < LEVELS - 1; i++) begin
                if (IDX_W'(i) >= hit_idx) begin
                  new_p[i] = sel_p[i+1];
                  new_q[i] = sel_q[i+1];
                end
              end
              new_p[LEVELS-1] = side_empty;
              new_q[LEVELS-1] = '0;
            end else begin
              wr = 1'b1;
              new_q[hit_idx] = cur_q - cls.qty;
            end
          end
        end
      end
      REQ_NONE: begin
      end
    endcase
  end

  always_comb begin
    res_nxt.error          = err_nxt;
    res_nxt.dropped        = drop;
    res_nxt.best_bid_price = bid_p_r[0];
    res_nxt.best_bid_qty   = bid_q_r[0];
    res_nxt.best_ask_price = ask_p_r[0];
    res_nxt.best_ask_qty   = ask_q_r[0];
    if (clear) begin
      res_nxt.best_bid_price = empty_bid_price;
      res_nxt.best_bid_qty   = '0;
      res_nxt.best_ask_price = empty_ask_price;
      res_nxt.best_ask_qty   = '0;
    end else if (wr && cls.side) begin
      res_nxt.best_ask_price = new_p[0];
      res_nxt.best_ask_qty   = new_q[0];
    end else if (wr) begin
      res_nxt.best_bid_price = new_p[0];
      res_nxt.best_bid_qty   = new_q[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        bid_p_r[i] <= '0;
        bid_q_r[i] <= '0;
        ask_p_r[i] <= '1;
        ask_q_r[i] <= '0;
      end
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pop;
      if (pop) begin
        err_r <= err_nxt;
        if (clear) begin
          for (int i = 0; i < LEVELS; i++) begin
            bid_p_r[i] <= empty_bid_price;
            bid_q_r[i] <= '0;
            ask_p_r[i] <= empty_ask_price;
            ask_q_r[i] <= '0;
          end
        end else if (wr && cls.side) begin
          ask_p_r <= new_p;
          ask_q_r <= new_q;
        end else if (wr) begin
          bid_p_r <= new_p;
          bid_q_r <= new_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res_r <= res_nxt;
    end
  end

endmodule

[src/top_n_order_book_levels.sv]
// Top level of the top-N order book price level tracker.
`timescale 1ns / 1ps
// Usage:
//  - Input: drive in_req and raise start; the transaction is taken at a rising
//    edge with start high and busy low. busy stays high until the result shows.
//  - Result: out_valid pulses for one cycle with out_res (sticky error,
//    dropped flag and best bid/ask level). There is no back-pressure; the
//    receiver must take it in that cycle.
//  - Config: cfg_we, cfg_idx, cfg_wdata write empty bid price (0), empty ask
//    price (1) and max level quantity (2); other indexes are ignored. Write
//    only while busy is low and no result is pending.
//  - Flow: after the accept edge the front end compares the price against every
//    level of the chosen side, the entry passes through the queue into the back
//    end, and there the table is shifted or updated. out_valid rises at the edge
//    where busy drops, so a new transaction is taken only after the last one has
//    retired. The compare-then-update dependency on the level tables sets this.
//  - Reset: synchronous, active low. Bid levels read price 0, ask levels all
//    ones, quantities zero, error clear, config at its reset values.
module top_n_order_book_levels #(
  parameter int LEVELS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  tnob_pkg::req_t                      in_req,
  output logic                                out_valid,
  output tnob_pkg::res_t                      out_res,
  input  logic                                cfg_we,
  input  logic [tnob_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [tnob_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tnob_pkg::*;

  localparam int IDX_W       = $clog2(LEVELS);
  localparam int ENT_W       = $bits(cls_t) + 2 * IDX_W;
  localparam int QUEUE_DEPTH = 2;

  logic                  busy_r;
  logic                  accept;
  logic [PRICE_BITS-1:0] empty_bid_r, empty_ask_r;
  logic [QTY_BITS-1:0]   max_qty_r;

  logic                  fr_push, fr_valid;
  logic [ENT_W-1:0]      fr_data, q_data;
  logic                  q_full, q_empty, q_pop;
  logic [PRICE_BITS-1:0] bid_price [LEVELS];
  logic [PRICE_BITS-1:0] ask_price [LEVELS];

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // one transaction in flight: busy drops when the back end retires it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (q_pop) begin
      busy_r <= 1'b0;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_bid_r <= '0;
      empty_ask_r <= '1;
      max_qty_r   <= '1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_EMPTY_BID: empty_bid_r <= cfg_wdata[PRICE_BITS-1:0];
        CFG_EMPTY_ASK: empty_ask_r <= cfg_wdata[PRICE_BITS-1:0];
        CFG_MAX_QTY:   max_qty_r   <= cfg_wdata[QTY_BITS-1:0];
        CFG_UNUSED:    ;
      endcase
    end
  end

  tnob_front #(.LEVELS(LEVELS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .item      (in_req),
    .bid_price (bid_price),
    .ask_price (ask_price),
    .q_full    (q_full),
    .push      (fr_push),
    .push_data (fr_data),
    .valid     (fr_valid)
  );

  tnob_fifo #(.W(ENT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fr_push),
    .push_data (fr_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  tnob_back #(.LEVELS(LEVELS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .pop_data        (q_data),
    .empty_bid_price (empty_bid_r),
    .empty_ask_price (empty_ask_r),
    .max_level_qty   (max_qty_r),
    .pop             (q_pop),
    .bid_price       (bid_price),
    .ask_price       (ask_price),
    .out_valid       (out_valid),
    .out_res         (out_res)
  );

  // a transaction is never in the front end and the queue at once
  a_single_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(fr_valid && !q_empty))
    else $error("front end and queue both hold a transaction");

  // every accepted transaction retires with a result strobe after busy rises
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> ##2 out_valid)
    else $error("result strobe missing after accepted transaction");

  // the result strobe only follows a transaction in flight
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy_r && $past(busy_r)))
    else $error("result strobe without a transaction in flight");

endmodule

[verif/tnob_book_checker.sv]
// Checker that predicts best bid/ask results of the order book block and compares them.
`timescale 1ns / 1ps
module tnob_book_checker #(
  parameter int LEVELS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  tnob_pkg::req_t                  in_req,
  input  logic                            out_valid,
  input  tnob_pkg::res_t                  out_res,
  input  logic                            cfg_we,
  input  logic [tnob_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tnob_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pend_cnt
);
  import tnob_pkg::*;

  // Shadow book and configuration
  logic [PRICE_BITS-1:0] bid_px [LEVELS];
  logic [QTY_BITS-1:0]   bid_qt [LEVELS];
  logic [PRICE_BITS-1:0] ask_px [LEVELS];
  logic [QTY_BITS-1:0]   ask_qt [LEVELS];
  logic                  err_flag;
  logic [PRICE_BITS-1:0] empty_bid;
  logic [PRICE_BITS-1:0] empty_ask;
  logic [QTY_BITS-1:0]   max_qty;

  res_t view_q [$];
  res_t want;
  int   fails = 0;

  function automatic void clear_book();
    for (int i = 0; i < LEVELS; i++) begin
      bid_px[i] = empty_bid;
      bid_qt[i] = '0;
      ask_px[i] = empty_ask;
      ask_qt[i] = '0;
    end
    err_flag = 1'b0;
  endfunction

  // Insert or remove on one side; returns the dropped flag.
  function automatic logic apply_side(input logic is_rem, input logic is_ask,
                                      input logic [PRICE_BITS-1:0] price,
                                      input logic [QTY_BITS-1:0] qty);
    logic [PRICE_BITS-1:0] px [LEVELS];
    logic [QTY_BITS-1:0]   qt [LEVELS];
    logic [QTY_BITS:0]     sum;
    int                    n_match;
    int                    hit;
    int                    worse;
    logic                  drop;
    logic                  better;
    if (is_ask) begin
      px = ask_px;
      qt = ask_qt;
    end else begin
      px = bid_px;
      qt = bid_qt;
    end
    n_match = 0;
    hit     = 0;
    worse   = -1;
    drop    = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      better = is_ask ? (price < px[i]) : (price > px[i]);
      if (px[i] == price) begin
        n_match++;
        hit = i;
      end
      if (better && worse < 0) worse = i;
    end
    if (qty == '0 || n_match > 1) begin
      err_flag = 1'b1;
    end else if (!is_rem) begin
      if (n_match == 1) begin
        sum = {1'b0, qt[hit]} + {1'b0, qty};
        if (sum > {1'b0, max_qty}) err_flag = 1'b1;
        else qt[hit] = sum[QTY_BITS-1:0];
      end else if (worse < 0) begin
        drop = 1'b1;
      end else begin
        for (int i = LEVELS - 1; i > worse; i--) begin
          px[i] = px[i-1];
          qt[i] = qt[i-1];
        end
        px[worse] = price;
        qt[worse] = qty;
      end
    end else begin
      if (n_match == 0 || qt[hit] < qty) begin
        err_flag = 1'b1;
      end else if (qt[hit] == qty) begin
        for (int i = hit; i < LEVELS - 1; i++) begin
          px[i] = px[i+1];
          qt[i] = qt[i+1];
        end
        px[LEVELS-1] = is_ask ? empty_ask : empty_bid;
        qt[LEVELS-1] = '0;
      end else begin
        qt[hit] = qt[hit] - qty;
      end
    end
    if (is_ask) begin
      ask_px = px;
      ask_qt = qt;
    end else begin
      bid_px = px;
      bid_qt = qt;
    end
    return drop;
  endfunction

  function automatic res_t predict_view(input req_t r);
    res_t v;
    logic drop;
    drop = 1'b0;
    case (r.req_type)
      REQ_CLEAR: clear_book();
      REQ_INSERT, REQ_REMOVE: begin
        if (!err_flag) drop = apply_side(r.req_type == REQ_REMOVE, r.side, r.price, r.qty);
      end
      default: ;
    endcase
    v.error          = err_flag;
    v.dropped        = drop;
    v.best_bid_price = bid_px[0];
    v.best_bid_qty   = bid_qt[0];
    v.best_ask_price = ask_px[0];
    v.best_ask_qty   = ask_qt[0];
    return v;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      empty_bid = '0;
      empty_ask = '1;
      max_qty   = '1;
      clear_book();
      view_q.delete();
    end else begin
      if (out_valid) begin
        if (view_q.size() == 0) begin
          $error("result transaction with no request outstanding");
          fails++;
        end else begin
          want = view_q.pop_front();
          check_field("error", 64'(want.error), 64'(out_res.error));
          check_field("dropped", 64'(want.dropped), 64'(out_res.dropped));
          check_field("best_bid_price", 64'(want.best_bid_price),
                      64'(out_res.best_bid_price));
          check_field("best_bid_qty", 64'(want.best_bid_qty),
                      64'(out_res.best_bid_qty));
          check_field("best_ask_price", 64'(want.best_ask_price),
                      64'(out_res.best_ask_price));
          check_field("best_ask_qty", 64'(want.best_ask_qty),
                      64'(out_res.best_ask_qty));
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_EMPTY_BID: empty_bid = cfg_wdata[PRICE_BITS-1:0];
          CFG_EMPTY_ASK: empty_ask = cfg_wdata[PRICE_BITS-1:0];
          CFG_MAX_QTY:   max_qty   = cfg_wdata[QTY_BITS-1:0];
          default: ;
        endcase
      end
      if (start && !busy) view_q.push_back(predict_view(in_req));
    end
    pend_cnt   <= view_q.size();
    fail_count <= fails;
  end

endmodule

[verif/tb_top.sv]
// Testbench top: stimulus, phases of configuration and the final verdict for the order book.
`timescale 1ns / 1ps
module tb_top;
  import tnob_pkg::*;

  localparam int LEVELS = 8;
  localparam int POOL   = 12;      // prices per side in a phase's pool
  localparam int LIMIT  = 200000;  // cycle budget, far above a slow correct run

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  req_t                  in_req    = '0;
  logic                  out_valid;
  res_t                  out_res;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pend_cnt;
  int cycle_cnt = 0;

  // Stimulus knobs, changed per phase
  int                    idle_pct = 0;
  int                    qty_hi   = 20;
  logic [PRICE_BITS-1:0] bid_base = 32'd1000;
  logic [PRICE_BITS-1:0] ask_base = 32'd1010;
  logic                  err_seen = 1'b0;

  // Recently inserted prices, so removes mostly hit a live level
  logic [PRICE_BITS-1:0] bid_seen [$];
  logic [PRICE_BITS-1:0] ask_seen [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  top_n_order_book_levels #(.LEVELS(LEVELS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  tnob_book_checker #(.LEVELS(LEVELS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pend_cnt   (pend_cnt)
  );

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Sticky error as seen on the result side; steers the random mix toward clears
  always @(posedge clk) begin
    if (!rst_n) err_seen <= 1'b0;
    else if (out_valid) err_seen <= out_res.error;
  end

  function automatic req_t mk_req(input req_type_t t, input logic s,
                                  input logic [PRICE_BITS-1:0] p,
                                  input logic [QTY_BITS-1:0] q);
    req_t r;
    r.req_type = t;
    r.side     = s;
    r.price    = p;
    r.qty      = q;
    return r;
  endfunction

  // Random request: mostly well-formed book traffic on a small price pool,
  // with clears, unused request codes and full-range noise mixed in.
  function automatic req_t make_req();
    req_t                  r;
    int                    sel;
    logic [PRICE_BITS-1:0] base;
    r.side     = 1'($urandom_range(0, 1));
    r.price    = $urandom;
    r.qty      = 16'($urandom);
    r.req_type = REQ_NONE;
    base       = r.side ? ask_base : bid_base;
    sel        = $urandom_range(0, 99);
    if (err_seen && $urandom_range(0, 99) < 60) begin
      r.req_type = REQ_CLEAR;
    end else if (sel < 52) begin
      r.req_type = REQ_INSERT;
      r.price    = base + $urandom_range(0, POOL - 1);
      r.qty      = 16'($urandom_range(1, qty_hi));
    end else if (sel < 84) begin
      r.req_type = REQ_REMOVE;
      if (r.side && ask_seen.size() > 0 && $urandom_range(0, 4) != 0)
        r.price = ask_seen[$urandom_range(0, ask_seen.size() - 1)];
      else if (!r.side && bid_seen.size() > 0 && $urandom_range(0, 4) != 0)
        r.price = bid_seen[$urandom_range(0, bid_seen.size() - 1)];
      else
        r.price = base + $urandom_range(0, POOL - 1);
      r.qty = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, qty_hi))
                                          : 16'($urandom_range(1, 3));
    end else if (sel < 89) begin
      r.req_type = REQ_CLEAR;
    end else if (sel < 92) begin
      r.req_type = REQ_NONE;
    end else begin
      // noise: any price, any qty, zero qty now and then
      r.req_type = req_type_t'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) r.qty = '0;
    end
    return r;
  endfunction

  // Present one transaction and hold it until the block takes it.
  // Returns in the time step of the accepting edge.
  task automatic send(input req_t r);
    in_req <= r;
    start  <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (r.req_type == REQ_INSERT) begin
      if (r.side) begin
        ask_seen.push_back(r.price);
        if (ask_seen.size() > 8) void'(ask_seen.pop_front());
      end else begin
        bid_seen.push_back(r.price);
        if (bid_seen.size() > 8) void'(bid_seen.pop_front());
      end
    end
  endtask

  // Random sender idle cycles between transactions
  task automatic gap();
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pend_cnt != 0) @(posedge clk);
  endtask

  // Write all registers back to back while idle; the unused index gets junk
  task automatic program_cfg(input logic [CFG_DATA_W-1:0] eb,
                             input logic [CFG_DATA_W-1:0] ea,
                             input logic [CFG_DATA_W-1:0] mq);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_EMPTY_BID;
    cfg_wdata <= eb;
    @(posedge clk);
    cfg_idx   <= CFG_EMPTY_ASK;
    cfg_wdata <= ea;
    @(posedge clk);
    cfg_idx   <= CFG_MAX_QTY;
    cfg_wdata <= mq;
    @(posedge clk);
    cfg_idx   <= CFG_UNUSED;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One phase of random traffic; opens with a clear so new empty prices apply
  task automatic run_phase(input int n, input int idle,
                           input logic [PRICE_BITS-1:0] bbase,
                           input logic [PRICE_BITS-1:0] abase, input int qhi);
    idle_pct = idle;
    bid_base = bbase;
    ask_base = abase;
    qty_hi   = qhi;
    send(mk_req(REQ_CLEAR, 1'b0, '0, '0));
    gap();
    for (int i = 0; i < n; i++) begin
      send(make_req());
      gap();
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed transactions, reset config: empty bid 0, empty ask all ones
    send(mk_req(REQ_INSERT, 1'b0, 32'd100, 16'd5));
    send(mk_req(REQ_INSERT, 1'b0, 32'd100, 16'd3));           // add to matching level
    send(mk_req(REQ_INSERT, 1'b0, 32'hFFFF_FFFF, 16'd1));     // new best bid at top price
    send(mk_req(REQ_INSERT, 1'b1, 32'd0, 16'hFFFF));          // lowest ask, full qty
    send(mk_req(REQ_INSERT, 1'b1, 32'd0, 16'd1));             // overflow past max
    send(mk_req(REQ_REMOVE, 1'b0, 32'd100, 16'd1));           // blocked by sticky error
    send(mk_req(REQ_CLEAR, 1'b1, 32'h5A5A_5A5A, 16'hA5A5));
    send(mk_req(REQ_NONE, 1'b1, 32'hFFFF_FFFF, 16'hFFFF));    // unused code, ignored
    send(mk_req(REQ_INSERT, 1'b0, 32'd7, 16'd0));             // zero quantity
    send(mk_req(REQ_CLEAR, 1'b0, '0, '0));
    send(mk_req(REQ_INSERT, 1'b1, 32'hFFFF_FFFF, 16'd1));     // matches several empty asks
    send(mk_req(REQ_CLEAR, 1'b0, '0, '0));
    send(mk_req(REQ_REMOVE, 1'b1, 32'd500, 16'd1));           // remove with no match
    send(mk_req(REQ_CLEAR, 1'b0, '0, '0));
    for (int i = 1; i <= LEVELS - 1; i++)
      send(mk_req(REQ_INSERT, 1'b0, 32'(10 * i), 16'(i)));
    send(mk_req(REQ_INSERT, 1'b0, 32'd0, 16'd2));             // lone empty level matches
    send(mk_req(REQ_INSERT, 1'b0, 32'd5, 16'd1));             // pushes the empty level out
    send(mk_req(REQ_INSERT, 1'b0, 32'd3, 16'd1));             // worse than all: dropped
    send(mk_req(REQ_REMOVE, 1'b0, 32'd40, 16'd4));            // level emptied, refill below
    send(mk_req(REQ_REMOVE, 1'b0, 32'd70, 16'd8));            // remove more than held
    send(mk_req(REQ_CLEAR, 1'b0, '0, '0));
    drain();

    // Random phases across settings, the extremes among them
    run_phase(130, 0, 32'd1000, 32'd1010, 20);

    program_cfg(32'h0000_1000, 32'h0000_2000, 32'hABCD_0010);  // max masks to 16
    run_phase(150, 56, 32'h0000_0FFC, 32'h0000_1FFA, 8);

    program_cfg(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
    run_phase(60, 6, 32'hFFFF_FFF4, 32'h0000_0000, 2);

    program_cfg(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF);
    run_phase(150, 56, 32'h0000_0000, 32'hFFFF_FFF4, 40000);

    program_cfg(32'd500, 32'd600, 32'd300);
    run_phase(75, 0, 32'd490, 32'd590, 100);
    run_phase(75, 6, 32'd490, 32'd590, 100);

    // Let any stray result show up before the verdict
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
